// File: rtl/sqwg_pkg.sv
// ----------------------------------------------------------------------------
// sqwg_pkg
// Shared constants and helpers for the quadrature weight generator.
// ----------------------------------------------------------------------------
package sqwg_pkg;

  localparam int unsigned MAX_BANDWIDTH = 64;
  localparam int unsigned FRACTION_BITS = 30;
  localparam int unsigned CORDIC_STEPS  = 30;
  localparam int unsigned K_IDX_W       = $clog2(MAX_BANDWIDTH);

  // register indexes
  localparam logic [1:0] REG_BANDWIDTH    = 2'd0;
  localparam logic [1:0] REG_ANGLE_UNIT   = 2'd1;
  localparam logic [1:0] REG_WEIGHT_SCALE = 2'd2;

  localparam logic signed [33:0] CORDIC_K = 34'sd652032874;

  function automatic logic signed [39:0] atan_lut(input logic [4:0] idx);
    logic signed [39:0] v;
    unique case (idx)
      5'd0:  v = 40'sd843314856;
      5'd1:  v = 40'sd497837829;
      5'd2:  v = 40'sd263043836;
      5'd3:  v = 40'sd133525158;
      5'd4:  v = 40'sd67021686;
      5'd5:  v = 40'sd33543515;
      5'd6:  v = 40'sd16775850;
      5'd7:  v = 40'sd8388437;
      5'd8:  v = 40'sd4194282;
      5'd9:  v = 40'sd2097149;
      5'd10: v = 40'sd1048575;
      5'd11: v = 40'sd524287;
      5'd12: v = 40'sd262143;
      5'd13: v = 40'sd131071;
      5'd14: v = 40'sd65535;
      5'd15: v = 40'sd32767;
      5'd16: v = 40'sd16383;
      5'd17: v = 40'sd8191;
      5'd18: v = 40'sd4095;
      5'd19: v = 40'sd2047;
      5'd20: v = 40'sd1023;
      5'd21: v = 40'sd511;
      5'd22: v = 40'sd255;
      5'd23: v = 40'sd127;
      5'd24: v = 40'sd63;
      5'd25: v = 40'sd31;
      5'd26: v = 40'sd15;
      5'd27: v = 40'sd7;
      5'd28: v = 40'sd3;
      5'd29: v = 40'sd1;
      default: v = 40'sd0;
    endcase
    return v;
  endfunction

  // saturate to signed 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [73:0] v);
    logic signed [31:0] r;
    if (v > 74'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -74'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // round-half-up of a fixed point product, floor shift
  function automatic logic signed [73:0] rnd(input logic signed [73:0] v);
    logic signed [73:0] s;
    s = v + (74'sd1 <<< (FRACTION_BITS - 1));
    return s >>> FRACTION_BITS;
  endfunction

endpackage

// File: rtl/sphere_quadrature_weight_gen_unit.sv
// ----------------------------------------------------------------------------
// sphere_quadrature_weight_gen_unit
// Quadrature weight generator: shared CORDIC for sines, one shared 33x33
// multiplier, reciprocal ROM, sequenced per sample index.
// ----------------------------------------------------------------------------
// Sequence: an out-of-range index gives its error result in the cycle after
//   accept. Each sine is computed by the 30-step CORDIC.
// Throughput: one item at a time; busy_o is high while a valid index is in process.
// Result: valid_o high for one cycle; the receiver cannot stall.
// Reset: asynchronous, clears sequencer, valid flag and config registers; datapath has no reset.
module sphere_quadrature_weight_gen_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [6:0]  sample_index_i,
  output logic        valid_o,
  output logic signed [31:0] even_weight_o,
  output logic signed [31:0] odd_weight_o,
  output logic        index_error_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  import sqwg_pkg::*;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_ZMUL  = 4'd1;
  localparam logic [3:0] ST_ZLOAD = 4'd2;
  localparam logic [3:0] ST_ROT   = 4'd3;
  localparam logic [3:0] ST_SINE  = 4'd4;
  localparam logic [3:0] ST_TMUL  = 4'd5;
  localparam logic [3:0] ST_TACC  = 4'd6;
  localparam logic [3:0] ST_LLO   = 4'd7;
  localparam logic [3:0] ST_LHI   = 4'd8;
  localparam logic [3:0] ST_LSUM  = 4'd9;
  localparam logic [3:0] ST_WMUL  = 4'd10;
  localparam logic [3:0] ST_WRES  = 4'd11;
  localparam logic [3:0] ST_OMUL  = 4'd12;
  localparam logic [3:0] ST_ORES  = 4'd13;

  // reciprocal ROM, round-half-up of 2^F/(2k+1)
  logic [30:0] recip_rom [MAX_BANDWIDTH];
  for (genvar g = 0; g < MAX_BANDWIDTH; g++) begin : g_rom
    localparam longint unsigned Den = 2 * g + 1;
    localparam longint unsigned Rv  = ((64'd1 << FRACTION_BITS) + Den / 2) / Den;
    assign recip_rom[g] = 31'(Rv);
  end

  logic [6:0]  bandwidth_q;
  logic [29:0] angle_unit_q;
  logic [31:0] weight_scale_q;

  logic [3:0]  state_q, state_d;
  logic [6:0]  b_q;
  logic [8:0]  p_q, stride_q;
  logic [1:0]  quad_q;
  logic [K_IDX_W-1:0] k_q;
  logic [4:0]  i_q;
  logic        first_q;
  logic signed [33:0] x_q, y_q;
  logic signed [39:0] z_q, acc_q;
  logic signed [31:0] s1_q, sine_q, t_q, even_q;
  logic signed [73:0] long_q;
  logic signed [65:0] prod_q;
  logic signed [32:0] mul_a, mul_b;
  logic        valid_q, err_q;
  logic signed [31:0] even_out_q, odd_out_q;

  // effective bandwidth, clipped to the maximum
  logic [6:0] b_eff;
  assign b_eff = (bandwidth_q > 7'(MAX_BANDWIDTH)) ? 7'(MAX_BANDWIDTH) : bandwidth_q;

  // quadrant split of the phase
  logic [9:0] quarter, p_ext, q_base;
  logic [1:0] quad_d;
  logic [6:0] resid;
  always_comb begin
    quarter = {2'b0, b_q, 1'b0};
    p_ext   = {1'b0, p_q};
    priority if (p_ext >= 10'(quarter * 3)) begin
      quad_d = 2'd3; q_base = 10'(quarter * 3);
    end else if (p_ext >= 10'(quarter * 2)) begin
      quad_d = 2'd2; q_base = 10'(quarter * 2);
    end else if (p_ext >= quarter) begin
      quad_d = 2'd1; q_base = quarter;
    end else begin
      quad_d = 2'd0; q_base = 10'd0;
    end
    resid = 7'(p_ext - q_base);
  end

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_ZMUL: begin
        mul_a = {26'b0, resid};
        mul_b = {3'b0, angle_unit_q};
      end
      ST_TMUL: begin
        mul_a = {sine_q[31], sine_q};
        mul_b = {2'b0, recip_rom[k_q]};
      end
      ST_LLO: begin
        mul_a = {17'b0, acc_q[15:0]};
        mul_b = {s1_q[31], s1_q};
      end
      ST_LHI: begin
        mul_a = {{9{acc_q[39]}}, acc_q[39:16]};
        mul_b = {s1_q[31], s1_q};
      end
      ST_WMUL: begin
        mul_a = {t_q[31], t_q};
        mul_b = {1'b0, weight_scale_q};
      end
      ST_OMUL: begin
        mul_a = {even_q[31], even_q};
        mul_b = {s1_q[31], s1_q};
      end
      default: ;
    endcase
  end

  logic signed [73:0] prod_ext, prod_rnd, long_sum;
  logic signed [33:0] xs, ys;
  logic signed [39:0] atan_v;
  logic signed [33:0] sine_sel;
  logic [9:0] p_next;
  always_comb begin
    prod_ext = {{8{prod_q[65]}}, prod_q};
    prod_rnd = rnd(prod_ext);
    long_sum = long_q + (prod_ext <<< 16);
    xs       = x_q >>> i_q;
    ys       = y_q >>> i_q;
    atan_v   = atan_lut(i_q);
    unique case (quad_q)
      2'd0: sine_sel = y_q;
      2'd1: sine_sel = x_q;
      2'd2: sine_sel = -y_q;
      default: sine_sel = -x_q;
    endcase
    p_next = {1'b0, p_q} + {1'b0, stride_q};
    if (p_next >= {b_q, 3'b0}) p_next = p_next - {b_q, 3'b0};
  end

  logic accept;
  assign accept = start_i && !busy_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (accept && ({1'b0, sample_index_i} < {b_eff, 1'b0})) state_d = ST_ZMUL;
      ST_ZMUL:  state_d = ST_ZLOAD;
      ST_ZLOAD: state_d = ST_ROT;
      ST_ROT:   if (i_q == 5'(CORDIC_STEPS - 1)) state_d = ST_SINE;
      ST_SINE:  state_d = first_q ? ST_ZMUL : ST_TMUL;
      ST_TMUL:  state_d = ST_TACC;
      ST_TACC:  state_d = ({1'b0, k_q} == 7'(b_q - 7'd1)) ? ST_LLO : ST_ZMUL;
      ST_LLO:   state_d = ST_LHI;
      ST_LHI:   state_d = ST_LSUM;
      ST_LSUM:  state_d = ST_WMUL;
      ST_WMUL:  state_d = ST_WRES;
      ST_WRES:  state_d = ST_OMUL;
      ST_OMUL:  state_d = ST_ORES;
      ST_ORES:  state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      valid_q        <= 1'b0;
      bandwidth_q    <= 7'd1;
      angle_unit_q   <= 30'd843314857;
      weight_scale_q <= 32'd2147483648;
    end else begin
      state_q <= state_d;
      valid_q <= 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          REG_BANDWIDTH:    bandwidth_q    <= cfg_data_i[6:0];
          REG_ANGLE_UNIT:   angle_unit_q   <= cfg_data_i[29:0];
          REG_WEIGHT_SCALE: weight_scale_q <= cfg_data_i;
          default: ;
        endcase
      end
      if ((state_q == ST_IDLE && accept && !({1'b0, sample_index_i} < {b_eff, 1'b0}))
          || state_q == ST_ORES) begin
        valid_q <= 1'b1;
      end
    end
  end

  // datapath, no reset
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          b_q        <= b_eff;
          p_q        <= {1'b0, sample_index_i, 1'b1};
          stride_q   <= {sample_index_i, 2'b10};
          k_q        <= '0;
          first_q    <= 1'b1;
          acc_q      <= '0;
          err_q      <= 1'b1;
          even_out_q <= '0;
          odd_out_q  <= '0;
        end
      end
      ST_ZMUL:  quad_q <= quad_d;
      ST_ZLOAD: begin
        z_q <= prod_q[39:0];
        x_q <= CORDIC_K;
        y_q <= '0;
        i_q <= '0;
      end
      ST_ROT: begin
        if (!z_q[39]) begin
          x_q <= x_q - ys; y_q <= y_q + xs; z_q <= z_q - atan_v;
        end else begin
          x_q <= x_q + ys; y_q <= y_q - xs; z_q <= z_q + atan_v;
        end
        i_q <= i_q + 5'd1;
      end
      ST_SINE: begin
        sine_q  <= sat32({{40{sine_sel[33]}}, sine_sel});
        if (first_q) s1_q <= sat32({{40{sine_sel[33]}}, sine_sel});
        first_q <= 1'b0;
      end
      ST_TACC: begin
        acc_q <= acc_q + prod_rnd[39:0];
        p_q   <= p_next[8:0];
        k_q   <= k_q + K_IDX_W'(1);
      end
      ST_LHI:  long_q <= prod_ext;
      ST_LSUM: t_q    <= sat32(rnd(long_sum));
      ST_WRES: even_q <= sat32(prod_rnd);
      ST_ORES: begin
        even_out_q <= even_q;
        odd_out_q  <= sat32(prod_rnd);
        err_q      <= 1'b0;
      end
      default: ;
    endcase
  end

  assign busy_o        = (state_q != ST_IDLE);
  assign valid_o       = valid_q;
  assign even_weight_o = even_out_q;
  assign odd_weight_o  = odd_out_q;
  assign index_error_o = err_q;
  assign cfg_ready_o   = 1'b1;

  // ---------------------------------------------------------------- checks
  a_valid_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy_o)
    else $error("result while busy");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && index_error_o) |-> (even_weight_o == 32'sd0 && odd_weight_o == 32'sd0))
    else $error("error result with nonzero weight");

  a_err_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !({1'b0, sample_index_i} < {b_eff, 1'b0})) |=> (valid_o && index_error_o))
    else $error("out of range index not flagged");

  a_rot_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROT) |-> (i_q < 5'(CORDIC_STEPS)))
    else $error("cordic step overrun");

endmodule
